// File: hdl/wvo_pkg.sv
package wvo_pkg;

  localparam int TABLE_SIZE_DEF = 1024;

  localparam int SAMPLE_W = 16;
  localparam int GAIN_W   = 16;
  localparam int FRAC_W   = 16;
  localparam int REL_W    = 17;
  localparam int MUL_W    = 18;
  localparam int PROD_W   = 2 * MUL_W;

  localparam logic [GAIN_W-1:0] GAIN_RST   = 16'd9830;
  localparam logic [GAIN_W-1:0] DECAY_RST  = 16'd64881;
  localparam logic [GAIN_W-1:0] THRESH_RST = 16'd328;
  localparam logic [REL_W-1:0]  REL_ONE    = 17'h10000;

  localparam logic signed [PROD_W-1:0] ROUND_HALF = PROD_W'(32768);

  localparam logic [63:0] TOP_OCTAVE [12] = '{
    64'd9290209,  64'd9842633,  64'd10427907, 64'd11047982,
    64'd11704930, 64'd12400941, 64'd13138339, 64'd13919586,
    64'd14747287, 64'd15624207, 64'd16553270, 64'd17537579
  };

  localparam logic [1:0] REG_GAIN   = 2'd0;
  localparam logic [1:0] REG_DECAY  = 2'd1;
  localparam logic [1:0] REG_THRESH = 2'd2;

  typedef enum logic [1:0] {
    MODE_TICK    = 2'd0,
    MODE_NOTE_ON = 2'd1,
    MODE_OFF_REL = 2'd2,
    MODE_OFF_NOW = 2'd3
  } mode_e;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_TICK_V1,
    ST_TICK_INT,
    ST_TICK_LVL,
    ST_TICK_REL,
    ST_TICK_DEC,
    ST_TICK_UPD,
    ST_NOTE_MUL,
    ST_NOTE_SET,
    ST_OUT
  } state_e;

endpackage

// File: hdl/wavetable_voice_oscillator.sv
// Channel   Direction  Handshake                      Payload
// apb       in         psel, penable, pwrite, pready  paddr, pwdata, prdata
// s_axis    in         s_axis_tvalid, s_axis_tready   tdata note/velocity, tuser mode
// m_axis    out        m_axis_tvalid, m_axis_tready   tdata sample, tuser voice_active
//
// A tick on a sounding voice passes the wave read, interpolation, level and release states,
// plus the decay states while releasing; a note on, a silent tick or a note off is shorter.
// The states share one 18x18 multiplier and the single read port of the wave ROM.
// Reset clears the voice and loads the default gain, decay and stop threshold.
// A waiting result sits in the output register; the next input transfer is taken meanwhile
// and the block holds only when a second result is ready before the first is taken.
module wavetable_voice_oscillator import wvo_pkg::*; #(
  parameter int TABLE_SIZE = TABLE_SIZE_DEF
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [23:0] s_axis_tdata,   // note [6:0], velocity [22:7], zero [23]
  input  logic [1:0]  s_axis_tuser,   // mode [1:0]
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [15:0] m_axis_tdata,   // sample [15:0]
  output logic [0:0]  m_axis_tuser    // voice_active [0]
);

  localparam int IDX_W  = $clog2(TABLE_SIZE);
  localparam int ADDR_W = $clog2(TABLE_SIZE + 1);
  localparam int PH_W   = IDX_W + FRAC_W;
  localparam int STEP_W = PH_W - 1;
  localparam logic [PH_W:0] PH_MOD = (PH_W + 1)'(TABLE_SIZE) << FRAC_W;

  typedef logic [STEP_W-1:0] pitch_mem_t [128];

  function automatic pitch_mem_t build_pitch();
    pitch_mem_t  p;
    logic [63:0] v;
    logic [63:0] r;
    int          m;
    int          sh;
    for (int i = 0; i < 128; i++) begin
      m = i + 4;
      sh = 20 - m / 12;
      v = TOP_OCTAVE[m % 12] * 64'(TABLE_SIZE);
      r = (v + (64'd1 << (sh - 1))) >> sh;
      p[i] = r[STEP_W-1:0];
    end
    return p;
  endfunction

  localparam pitch_mem_t PITCH = build_pitch();

  state_e state_q, state_d;

  logic [GAIN_W-1:0] gain_q;
  logic [GAIN_W-1:0] decay_q;
  logic [GAIN_W-1:0] thresh_q;
  logic [PH_W-1:0]   phase_q;
  logic [STEP_W-1:0] step_q;
  logic [GAIN_W-1:0] level_q;
  logic [REL_W-1:0]  rel_q;

  logic [STEP_W-1:0]          pitch_q;
  logic [GAIN_W-1:0]          vel_q;
  logic signed [SAMPLE_W-1:0] v0_q;
  logic [SAMPLE_W-1:0]        samp_q;
  logic signed [PROD_W-1:0]   prod_q;
  logic signed [PROD_W-1:0]   prod_d;

  logic                m_valid_q;
  logic [SAMPLE_W-1:0] m_data_q;
  logic                m_user_q;

  logic signed [SAMPLE_W-1:0] wave_data;
  logic [ADDR_W-1:0]          wave_addr;
  logic [ADDR_W-1:0]          idx;
  logic signed [MUL_W-1:0]    mul_a;
  logic signed [MUL_W-1:0]    mul_b;
  logic signed [PROD_W-1:0]   rnd_add;
  logic [SAMPLE_W:0]          diff;
  logic [SAMPLE_W:0]          x_lvl;
  logic [REL_W-1:0]           rel_new;
  logic [PH_W:0]              ph_sum;
  logic [PH_W:0]              ph_next;
  logic                       s_fire;
  logic                       out_load;
  logic                       cfg_wr;
  mode_e                      in_mode;

  assign in_mode  = mode_e'(s_axis_tuser);
  assign s_fire   = s_axis_tvalid && s_axis_tready;
  assign s_axis_tready = (state_q == ST_IDLE);
  assign out_load = (state_q == ST_OUT) && (!m_valid_q || m_axis_tready);
  assign cfg_wr   = psel && penable && pwrite && pready;

  assign idx     = ADDR_W'(phase_q[PH_W-1:FRAC_W]);
  assign diff    = {wave_data[SAMPLE_W-1], wave_data} - {v0_q[SAMPLE_W-1], v0_q};
  assign x_lvl   = {v0_q[SAMPLE_W-1], v0_q} + prod_q[FRAC_W+SAMPLE_W:FRAC_W];
  assign rel_new = prod_q[FRAC_W+REL_W-1:FRAC_W];
  assign ph_sum  = {1'b0, phase_q} + (PH_W + 1)'(step_q);
  assign ph_next = (ph_sum >= PH_MOD) ? ph_sum - PH_MOD : ph_sum;

  wvo_wave_rom #(
    .TABLE_SIZE (TABLE_SIZE),
    .ADDR_W     (ADDR_W)
  ) u_wave_rom (
    .clk_i  (clk_i),
    .addr_i (wave_addr),
    .data_o (wave_data)
  );

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (s_fire) begin
          unique case (in_mode)
            MODE_TICK:    state_d = (step_q != '0) ? ST_TICK_V1 : ST_OUT;
            MODE_NOTE_ON: state_d = ST_NOTE_MUL;
            MODE_OFF_REL: state_d = ST_OUT;
            MODE_OFF_NOW: state_d = ST_OUT;
          endcase
        end
      end
      ST_TICK_V1:  state_d = ST_TICK_INT;
      ST_TICK_INT: state_d = ST_TICK_LVL;
      ST_TICK_LVL: state_d = ST_TICK_REL;
      ST_TICK_REL: state_d = (rel_q != '0) ? ST_TICK_DEC : ST_OUT;
      ST_TICK_DEC: state_d = ST_TICK_UPD;
      ST_TICK_UPD: state_d = ST_OUT;
      ST_NOTE_MUL: state_d = ST_NOTE_SET;
      ST_NOTE_SET: state_d = ST_OUT;
      ST_OUT: begin
        if (out_load) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    wave_addr = idx;
    mul_a     = '0;
    mul_b     = '0;
    rnd_add   = '0;
    unique case (state_q)
      ST_TICK_V1: wave_addr = idx + ADDR_W'(1);
      ST_TICK_INT: begin
        mul_a   = {diff[SAMPLE_W], diff};
        mul_b   = {2'b00, phase_q[FRAC_W-1:0]};
        rnd_add = ROUND_HALF;
      end
      ST_TICK_LVL: begin
        mul_a   = {x_lvl[SAMPLE_W], x_lvl};
        mul_b   = {2'b00, level_q};
        rnd_add = ROUND_HALF;
      end
      ST_TICK_REL: begin
        mul_a   = {prod_q[FRAC_W+SAMPLE_W], prod_q[FRAC_W+SAMPLE_W:FRAC_W]};
        mul_b   = {1'b0, rel_q};
        rnd_add = ROUND_HALF;
      end
      ST_TICK_DEC: begin
        mul_a = {1'b0, rel_q};
        mul_b = {2'b00, decay_q};
      end
      ST_NOTE_MUL: begin
        mul_a   = {2'b00, vel_q};
        mul_b   = {2'b00, gain_q};
        rnd_add = ROUND_HALF;
      end
      default: begin
      end
    endcase
    prod_d = mul_a * mul_b + rnd_add;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      gain_q    <= GAIN_RST;
      decay_q   <= DECAY_RST;
      thresh_q  <= THRESH_RST;
      phase_q   <= '0;
      step_q    <= '0;
      level_q   <= '0;
      rel_q     <= '0;
      m_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (cfg_wr) begin
        case (paddr[3:2])
          REG_GAIN:   gain_q   <= pwdata[GAIN_W-1:0];
          REG_DECAY:  decay_q  <= pwdata[GAIN_W-1:0];
          REG_THRESH: thresh_q <= pwdata[GAIN_W-1:0];
          default: begin
          end
        endcase
      end
      if (out_load) begin
        m_valid_q <= 1'b1;
      end else if (m_axis_tready) begin
        m_valid_q <= 1'b0;
      end
      unique case (state_q)
        ST_IDLE: begin
          if (s_fire && in_mode == MODE_OFF_REL && rel_q == '0) begin
            rel_q <= REL_ONE;
          end
          if (s_fire && in_mode == MODE_OFF_NOW) begin
            step_q <= '0;
            rel_q  <= '0;
          end
        end
        ST_TICK_REL: phase_q <= ph_next[PH_W-1:0];
        ST_TICK_UPD: begin
          if (rel_new <= {1'b0, thresh_q}) begin
            step_q <= '0;
            rel_q  <= '0;
          end else begin
            rel_q <= rel_new;
          end
        end
        ST_NOTE_MUL: begin
          phase_q <= '0;
          rel_q   <= '0;
          step_q  <= pitch_q;
        end
        ST_NOTE_SET: level_q <= prod_q[FRAC_W+GAIN_W-1:FRAC_W];
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    pitch_q <= PITCH[s_axis_tdata[6:0]];
    prod_q  <= prod_d;
    if (s_fire) begin
      vel_q  <= s_axis_tdata[22:7];
      samp_q <= '0;
    end
    if (state_q == ST_TICK_V1) begin
      v0_q <= wave_data;
    end
    if (state_q == ST_TICK_REL && rel_q == '0) begin
      samp_q <= prod_q[FRAC_W+SAMPLE_W-1:FRAC_W];
    end
    if (state_q == ST_TICK_DEC) begin
      samp_q <= prod_q[FRAC_W+SAMPLE_W-1:FRAC_W];
    end
    if (out_load) begin
      m_data_q <= samp_q;
      m_user_q <= (step_q != '0);
    end
  end

  always_comb begin
    case (paddr[3:2])
      REG_GAIN:   prdata = {16'h0000, gain_q};
      REG_DECAY:  prdata = {16'h0000, decay_q};
      REG_THRESH: prdata = {16'h0000, thresh_q};
      default:    prdata = '0;
    endcase
  end

  assign pready        = 1'b1;
  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tdata  = m_data_q;
  assign m_axis_tuser  = m_user_q;

endmodule

// File: hdl/wvo_wave_rom.sv
module wvo_wave_rom import wvo_pkg::*; #(
  parameter int TABLE_SIZE = TABLE_SIZE_DEF,
  parameter int ADDR_W = $clog2(TABLE_SIZE + 1)
) (
  input  logic                       clk_i,
  input  logic [ADDR_W-1:0]          addr_i,
  output logic signed [SAMPLE_W-1:0] data_o
);

  typedef logic signed [SAMPLE_W-1:0] wave_mem_t [TABLE_SIZE+1];

  function automatic logic [63:0] quarter_sine(input logic [63:0] u);
    logic [63:0] u2;
    logic [63:0] p;
    u2 = (u * u) >> 30;
    p = 64'd3864;
    p = 64'd172272 - ((u2 * p) >> 30);
    p = 64'd5026995 - ((u2 * p) >> 30);
    p = 64'd85569306 - ((u2 * p) >> 30);
    p = 64'd693598668 - ((u2 * p) >> 30);
    p = 64'd1686629713 - ((u2 * p) >> 30);
    return (p * u) >> 30;
  endfunction

  function automatic logic signed [SAMPLE_W-1:0] sine_entry(input int idx);
    logic [63:0] t;
    logic [63:0] quad;
    logic [63:0] rem;
    logic [63:0] v;
    logic [63:0] u;
    logic [63:0] m;
    t = 64'(idx) * 64'd4;
    quad = (t / TABLE_SIZE) & 64'd3;
    rem = t % TABLE_SIZE;
    v = quad[0] ? 64'(TABLE_SIZE) - rem : rem;
    u = (v << 30) / TABLE_SIZE;
    m = (quarter_sine(u) + 64'd16384) >> 15;
    if (m > 64'd32767) begin
      m = 64'd32767;
    end
    return quad[1] ? -$signed(m[SAMPLE_W-1:0]) : $signed(m[SAMPLE_W-1:0]);
  endfunction

  function automatic wave_mem_t build_wave();
    wave_mem_t w;
    for (int i = 0; i < TABLE_SIZE; i++) begin
      w[i] = sine_entry(i);
    end
    w[TABLE_SIZE] = w[0];
    return w;
  endfunction

  localparam wave_mem_t WAVE = build_wave();

  logic signed [SAMPLE_W-1:0] data_q;

  always_ff @(posedge clk_i) begin
    data_q <= WAVE[addr_i];
  end

  assign data_o = data_q;

endmodule

// File: dv/wavetable_voice_oscillator_tb.sv
module wavetable_voice_oscillator_tb;
  import wvo_pkg::*;

  localparam int TS = TABLE_SIZE_DEF;
  localparam logic [1:0] REG_UNUSED = 2'd3;
  localparam int PHASE_ITEMS = 85;
  localparam int RANDOM_PHASES = 6;
  localparam longint unsigned TOP_STEPS [12] = '{
    64'd9290209,  64'd9842633,  64'd10427907, 64'd11047982,
    64'd11704930, 64'd12400941, 64'd13138339, 64'd13919586,
    64'd14747287, 64'd15624207, 64'd16553270, 64'd17537579
  };

  typedef struct packed {
    logic signed [15:0] sample;
    logic               active;
  } voice_out_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [3:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [23:0] s_axis_tdata = '0;   // note [6:0], velocity [22:7], zero [23]
  logic [1:0]  s_axis_tuser = '0;   // mode [1:0]
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b1;
  logic [15:0] m_axis_tdata;        // sample [15:0]
  logic [0:0]  m_axis_tuser;        // voice_active [0]

  wavetable_voice_oscillator #(.TABLE_SIZE(TS)) dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .prdata        (prdata),
    .pready        (pready),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
  );

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  logic signed [15:0] sine_rom [0:TS];
  logic [24:0]        step_rom [0:127];
  logic [15:0]        gain_q = 16'd9830;
  logic [15:0]        decay_q = 16'd64881;
  logic [15:0]        thresh_q = 16'd328;
  logic [25:0]        osc_phase = '0;
  logic [24:0]        osc_step = '0;
  logic [15:0]        osc_level = '0;
  logic [16:0]        osc_release = '0;

  voice_out_t pending_voice_out [$];
  bit gaps_on = 1'b0;
  bit stalls_on = 1'b0;
  int items_sent = 0;
  int results_checked = 0;
  int reg_writes = 0;
  int mismatches = 0;

  function automatic longint unsigned quarter_sine_q30(longint unsigned u);
    longint unsigned u2, p;
    u2 = (u * u) >> 30;
    p = 3864;
    p = 172272 - ((u2 * p) >> 30);
    p = 5026995 - ((u2 * p) >> 30);
    p = 85569306 - ((u2 * p) >> 30);
    p = 693598668 - ((u2 * p) >> 30);
    p = 1686629713 - ((u2 * p) >> 30);
    return (p * u) >> 30;
  endfunction

  function automatic void build_tables();
    longint unsigned t, quad, rem, dist_in, u, mag, scaled, octave;
    int sh;
    for (int i = 0; i < TS; i++) begin
      t = longint'(i) * 4;
      quad = (t / TS) & 3;
      rem = t % TS;
      dist_in = quad[0] ? TS - rem : rem;
      u = (dist_in << 30) / TS;
      mag = (quarter_sine_q30(u) + 16384) >> 15;
      if (mag > 32767) mag = 32767;
      sine_rom[i] = quad[1] ? -16'(mag) : 16'(mag);
    end
    sine_rom[TS] = sine_rom[0];
    for (int n = 0; n < 128; n++) begin
      octave = n + 4;
      sh = 10 + (10 - int'(octave / 12));
      scaled = TOP_STEPS[octave % 12] * TS;
      step_rom[n] = 25'((scaled + (64'd1 << (sh - 1))) >> sh);
    end
  endfunction

  function automatic longint round16(longint v);
    return (v + 32768) >>> 16;
  endfunction

  function automatic voice_out_t predict_voice(mode_e mode, logic [6:0] note,
                                               logic [15:0] vel);
    voice_out_t r;
    longint v0, v1, x, frac;
    longint unsigned idx, rel;
    r.sample = '0;
    case (mode)
      MODE_NOTE_ON: begin
        osc_phase = '0;
        osc_release = '0;
        osc_level = 16'((longint'(vel) * longint'(gain_q) + 32768) >> 16);
        osc_step = step_rom[note];
      end
      MODE_OFF_REL: begin
        if (osc_release == 0) osc_release = REL_ONE;
      end
      MODE_OFF_NOW: begin
        osc_step = '0;
        osc_release = '0;
      end
      default: begin
        if (osc_step != 0) begin
          idx = (osc_phase >> 16) % TS;
          frac = longint'(osc_phase[15:0]);
          v0 = sine_rom[idx];
          v1 = sine_rom[idx + 1];
          x = v0 + round16((v1 - v0) * frac);
          x = round16(x * longint'(osc_level));
          if (osc_release != 0) x = round16(x * longint'(osc_release));
          r.sample = x[15:0];
          osc_phase = 26'((longint'(osc_phase) + longint'(osc_step)) % (longint'(TS) << 16));
          if (osc_release != 0) begin
            rel = (longint'(osc_release) * longint'(decay_q)) >> 16;
            osc_release = rel[16:0];
            if (osc_release <= thresh_q) begin
              osc_step = '0;
              osc_release = '0;
            end
          end
        end
      end
    endcase
    r.active = (osc_step != 0);
    return r;
  endfunction

  function automatic logic [15:0] reg_model(logic [1:0] idx);
    case (idx)
      REG_GAIN:   return gain_q;
      REG_DECAY:  return decay_q;
      REG_THRESH: return thresh_q;
      default:    return '0;
    endcase
  endfunction

  function automatic logic [15:0] pick_velocity();
    if ($urandom_range(0, 7) == 0) return $urandom_range(0, 1) ? 16'hFFFF : 16'h0000;
    return 16'($urandom);
  endfunction

  task automatic report_mismatch(string what);
    mismatches++;
    if (mismatches <= 50) $display("[%0t] mismatch: %s", $time, what);
  endtask

  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      results_checked++;
      if (pending_voice_out.size() == 0) begin
        report_mismatch($sformatf("result transfer %0d arrived with nothing expected",
                                  results_checked));
      end else begin
        voice_out_t want;
        want = pending_voice_out.pop_front();
        if (m_axis_tdata !== want.sample)
          report_mismatch($sformatf("result %0d sample got %0d want %0d", results_checked,
                                    $signed(m_axis_tdata), want.sample));
        if (m_axis_tuser[0] !== want.active)
          report_mismatch($sformatf("result %0d voice_active got %b want %b",
                                    results_checked, m_axis_tuser[0], want.active));
      end
    end
  end

  always begin
    @(negedge clk_i);
    if (stalls_on && $urandom_range(0, 5) == 0) begin
      m_axis_tready <= 1'b0;
      repeat ($urandom_range(1, 16)) @(negedge clk_i);
    end
    m_axis_tready <= 1'b1;
  end

  task automatic send_item(mode_e mode, logic [6:0] note, logic [15:0] vel);
    @(negedge clk_i);
    if (gaps_on && $urandom_range(0, 4) == 0) begin
      s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(1, 16)) @(negedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata <= {1'b0, vel, note};
    s_axis_tuser <= mode;
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    pending_voice_out.push_back(predict_voice(mode, note, vel));
    items_sent++;
  endtask

  task automatic send_tick();
    send_item(MODE_TICK, 7'($urandom), 16'($urandom));
  endtask

  task automatic wait_idle();
    @(negedge clk_i);
    s_axis_tvalid <= 1'b0;
    while (pending_voice_out.size() != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);
  endtask

  task automatic apb_write(logic [1:0] idx, logic [15:0] value);
    @(negedge clk_i);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 2'b00};
    pwdata <= {16'($urandom), value};
    @(negedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    while (!pready) @(posedge clk_i);
    case (idx)
      REG_GAIN:   gain_q = value;
      REG_DECAY:  decay_q = value;
      REG_THRESH: thresh_q = value;
      default: ;
    endcase
    reg_writes++;
    @(negedge clk_i);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
  endtask

  task automatic apb_read_check(logic [1:0] idx);
    @(negedge clk_i);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b0;
    paddr <= {idx, 2'b00};
    @(negedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    while (!pready) @(posedge clk_i);
    if (prdata[15:0] !== reg_model(idx))
      report_mismatch($sformatf("register %0d read %0d want %0d", idx, prdata[15:0],
                                reg_model(idx)));
    @(negedge clk_i);
    psel <= 1'b0;
    penable <= 1'b0;
  endtask

  task automatic set_voice_regs(logic [15:0] gain, logic [15:0] decay, logic [15:0] thresh);
    wait_idle();
    apb_write(REG_GAIN, gain);
    apb_write(REG_DECAY, decay);
    apb_write(REG_THRESH, thresh);
    apb_read_check(REG_GAIN);
    apb_read_check(REG_DECAY);
    apb_read_check(REG_THRESH);
  endtask

  task automatic test_register_access();
    apb_read_check(REG_GAIN);
    apb_read_check(REG_DECAY);
    apb_read_check(REG_THRESH);
    apb_write(REG_UNUSED, 16'($urandom));
    apb_read_check(REG_GAIN);
    apb_read_check(REG_DECAY);
    apb_read_check(REG_THRESH);
  endtask

  task automatic test_note_basics();
    send_tick();
    send_item(MODE_NOTE_ON, 7'd69, 16'hFFFF);
    repeat (3) send_tick();
    send_item(MODE_OFF_REL, 7'd0, 16'd0);
    send_item(MODE_OFF_REL, 7'h7F, 16'hFFFF);
    repeat (2) send_tick();
    send_item(MODE_OFF_NOW, 7'd0, 16'd0);
    send_tick();
  endtask

  task automatic test_field_extremes();
    send_item(MODE_NOTE_ON, 7'd127, 16'd0);
    repeat (2) send_tick();
    send_item(MODE_NOTE_ON, 7'd0, 16'hFFFF);
    send_tick();
    send_item(MODE_NOTE_ON, 7'd127, 16'hFFFF);
    repeat (5) send_tick();
    send_item(MODE_OFF_NOW, 7'h7F, 16'hFFFF);
    send_item(MODE_OFF_REL, 7'd0, 16'd0);
    send_tick();
  endtask

  task automatic test_release_extremes();
    set_voice_regs(16'hFFFF, 16'd0, 16'hFFFF);
    send_item(MODE_NOTE_ON, 7'd127, 16'hFFFF);
    send_item(MODE_OFF_REL, 7'd0, 16'd0);
    repeat (2) send_tick();
    set_voice_regs(16'hFFFF, 16'hFFFF, 16'd0);
    send_item(MODE_NOTE_ON, 7'd100, 16'hFFFF);
    send_item(MODE_OFF_REL, 7'd0, 16'd0);
    repeat (2) send_tick();
    set_voice_regs(16'd0, 16'd64881, 16'd328);
    send_item(MODE_NOTE_ON, 7'd64, 16'hFFFF);
    send_tick();
  endtask

  task automatic random_sequence();
    int kind;
    int len;
    kind = $urandom_range(0, 9);
    if (kind < 7) begin
      send_item(MODE_NOTE_ON, 7'($urandom), pick_velocity());
      len = $urandom_range(1, 24);
      repeat (len) send_tick();
      if ($urandom_range(0, 2) != 0) begin
        send_item(MODE_OFF_REL, 7'($urandom), 16'($urandom));
        len = $urandom_range(1, 60);
        while (len > 0 && osc_step != 0) begin
          send_tick();
          len--;
        end
        if ($urandom_range(0, 1)) send_tick();
      end else if ($urandom_range(0, 1)) begin
        send_item(MODE_OFF_NOW, 7'($urandom), 16'($urandom));
      end
    end else if (kind < 9) begin
      repeat ($urandom_range(1, 4))
        send_item(mode_e'(2'($urandom)), 7'($urandom), 16'($urandom));
    end else begin
      send_item(mode_e'(2'($urandom_range(2, 3))), 7'($urandom), 16'($urandom));
      send_tick();
      send_item(mode_e'(2'($urandom_range(2, 3))), 7'($urandom), 16'($urandom));
      send_tick();
    end
  endtask

  task automatic test_random_phases();
    int base_count;
    logic [15:0] decay, thresh;
    for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
      if (ph == RANDOM_PHASES - 1) begin
        gaps_on = 1'b0;
        stalls_on = 1'b0;
      end
      decay = ($urandom_range(0, 3) == 0) ? 16'($urandom) : 16'($urandom_range(52000, 64000));
      thresh = ($urandom_range(0, 3) == 0) ? 16'($urandom) : 16'($urandom_range(0, 3000));
      set_voice_regs(16'($urandom), decay, thresh);
      base_count = items_sent;
      while (items_sent - base_count < PHASE_ITEMS) random_sequence();
    end
  endtask

  initial begin
    build_tables();
    repeat (6) @(negedge clk_i);
    rst_ni <= 1'b1;
    gaps_on = 1'b1;
    stalls_on = 1'b1;
    test_register_access();
    test_note_basics();
    test_field_extremes();
    test_release_extremes();
    test_random_phases();
    wait_idle();
    repeat (16) @(posedge clk_i);
    $display("Sent %0d input transfers and checked %0d result transfers with %0d register writes.",
             items_sent, results_checked, reg_writes);
    $display("Stimulus mixed note on, ticks, both note offs, retriggers and register extremes.");
    if (mismatches == 0 && pending_voice_out.size() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

  initial begin
    #1000000;
    $display("CHECK FAILED");
    $finish;
  end

endmodule
